// File: rtl/usv_pkg.sv
// Package for the UTF-8 scalar validator: byte ranges, code point limits
// and the overlong bound table. No dependencies.
package usv_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    localparam logic [CP_W-1:0] CP_MIN2   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN3   = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4   = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;

    // Sequence length class: sets the smallest code point a form may carry
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_TWO  = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR = 2'd3;

    function automatic logic [CP_W-1:0] class_minimum(input logic [1:0] cls);
        logic [CP_W-1:0] v;
        unique case (cls)
            CLS_TWO:   v = CP_MIN2;
            CLS_THREE: v = CP_MIN3;
            CLS_FOUR:  v = CP_MIN4;
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/utf8_scalar_validator_core.sv
// UTF-8 scalar validator top level: input register, per-byte decode
// and result register. Depends on usv_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one byte of a string per beat,
//   with i_last_byte on the final byte. An empty string is a single beat
//   with i_empty_marker set; it yields a result of 0 and clears all state,
//   also when it arrives in the middle of a string.
//   Output channel (o_valid / i_ready) carries one beat per finished string:
//   o_string_valid is 1 when the string is non-empty, NUL-free, well-formed
//   UTF-8 scalar values with no sequence cut short.
//   A result passes through the input register and then the result
//   register before it shows on o_valid.
//   Throughput: one byte per cycle, save where a stall holds a final byte; the per-byte decode sits
//   between the input register and the state/result registers.
//   When the receiver stalls, bytes that finish no string keep flowing;
//   a byte that finishes a string waits in the input register until the
//   result register is free, and o_ready drops meanwhile.
//   Reset (synchronous, active low) empties both registers and clears state.
module utf8_scalar_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    input  logic       i_empty_marker,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_string_valid
);
    import usv_pkg::*;

    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    logic            r_in_empty;

    logic [1:0]      r_pend, n_pend;
    logic [CP_W-1:0] r_cp, n_cp;
    logic [1:0]      r_cls, n_cls;
    logic            r_err, n_err;

    logic            r_out_vld;
    logic            r_out_ok;

    logic            need_out;
    logic            adv;
    logic            ok;
    logic [CP_W-1:0] cp_shift;

    assign need_out = r_in_last | r_in_empty;
    assign adv      = r_in_vld & (~need_out | ~r_out_vld | i_ready);
    assign o_ready  = ~r_in_vld | adv;
    assign cp_shift = {r_cp[CP_W-7:0], r_in_byte[5:0]};

    always_comb begin
        n_pend = r_pend;
        n_cp   = r_cp;
        n_cls  = r_cls;
        n_err  = r_err;
        if (!r_err) begin
            if (r_pend == 2'd0) begin
                if (r_in_byte == 8'h00) begin
                    n_err = 1'b1;
                end else if (!r_in_byte[7]) begin
                    // plain ASCII: nothing to track
                end else if (r_in_byte >= LEAD2_LO && r_in_byte <= LEAD2_HI) begin
                    n_pend = 2'd1;
                    n_cp   = {16'd0, r_in_byte[4:0]};
                    n_cls  = CLS_TWO;
                end else if (r_in_byte >= LEAD3_LO && r_in_byte <= LEAD3_HI) begin
                    n_pend = 2'd2;
                    n_cp   = {17'd0, r_in_byte[3:0]};
                    n_cls  = CLS_THREE;
                end else if (r_in_byte >= LEAD4_LO && r_in_byte <= LEAD4_HI) begin
                    n_pend = 2'd3;
                    n_cp   = {18'd0, r_in_byte[2:0]};
                    n_cls  = CLS_FOUR;
                end else begin
                    n_err = 1'b1;
                end
            end else if ((r_in_byte & CONT_MASK) != CONT_TAG) begin
                n_err = 1'b1;
            end else begin
                n_pend = r_pend - 2'd1;
                n_cp   = cp_shift;
                if (r_pend == 2'd1) begin
                    // sequence complete: check overlong, range and surrogates
                    if (cp_shift < class_minimum(r_cls) || cp_shift > CP_MAX ||
                        (cp_shift >= SURR_LO && cp_shift <= SURR_HI)) begin
                        n_err = 1'b1;
                    end
                    n_cp  = '0;
                    n_cls = CLS_NONE;
                end
            end
        end
        ok = ~n_err & (n_pend == 2'd0) & ~r_in_empty;
        if (need_out) begin
            n_pend = 2'd0;
            n_cp   = '0;
            n_cls  = CLS_NONE;
            n_err  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_pend    <= 2'd0;
            r_cp      <= '0;
            r_cls     <= CLS_NONE;
            r_err     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (adv) begin
                r_pend <= n_pend;
                r_cp   <= n_cp;
                r_cls  <= n_cls;
                r_err  <= n_err;
            end
            if (adv && need_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_byte_value;
            r_in_last  <= i_last_byte;
            r_in_empty <= i_empty_marker;
        end
        if (adv && need_out) begin
            r_out_ok <= ok;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_string_valid = r_out_ok;

`ifndef SYNTH
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_vld && !r_out_vld))
        else $error("registers not empty after reset");

    a_idle_tracking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> (r_cls == CLS_NONE && r_cp == '0))
        else $error("sequence tracking left without pending continuations");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_empty) |=> (o_valid && !o_string_valid))
        else $error("empty string not reported invalid");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && need_out) |=> (r_pend == 2'd0 && !r_err && o_valid))
        else $error("state not cleared at end of string");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("pending result dropped");
`endif

endmodule
